### hdl/hrcd_pkg.sv
// Package: shared types and constants for the chunked response deframer.
package hrcd_pkg;

   typedef enum logic [6:0] {
      PH_STATUS  = 7'b0000001,
      PH_HEADERS = 7'b0000010,
      PH_BODY    = 7'b0000100,
      PH_CLEN    = 7'b0001000,
      PH_CEND    = 7'b0010000,
      PH_TRAIL   = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_STATUS   = 2'd1;
   localparam logic [1:0] ERR_NO_COLON = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_COLON = 8'h3A;

   localparam int CL_LEN      = 14;
   localparam int TE_LEN      = 17;
   localparam int CHUNKED_LEN = 7;

   localparam logic [9:0] STATUS_MAX = 10'd999;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] cl_char(input logic [4:0] i);
      case (i)
         5'd0: return "c";   5'd1: return "o";   5'd2: return "n";
         5'd3: return "t";   5'd4: return "e";   5'd5: return "n";
         5'd6: return "t";   5'd7: return "-";   5'd8: return "l";
         5'd9: return "e";   5'd10: return "n";  5'd11: return "g";
         5'd12: return "t";  5'd13: return "h";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] te_char(input logic [4:0] i);
      case (i)
         5'd0: return "t";   5'd1: return "r";   5'd2: return "a";
         5'd3: return "n";   5'd4: return "s";   5'd5: return "f";
         5'd6: return "e";   5'd7: return "r";   5'd8: return "-";
         5'd9: return "e";   5'd10: return "n";  5'd11: return "c";
         5'd12: return "o";  5'd13: return "d";  5'd14: return "i";
         5'd15: return "n";  5'd16: return "g";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] chunked_char(input logic [2:0] i);
      case (i)
         3'd0: return "c";  3'd1: return "h";  3'd2: return "u";
         3'd3: return "n";  3'd4: return "k";  3'd5: return "e";
         3'd6: return "d";
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [2:0] phase_code(input phase_type p);
      case (p)
         PH_STATUS:  return 3'd0;
         PH_HEADERS: return 3'd1;
         PH_BODY:    return 3'd2;
         PH_CLEN:    return 3'd3;
         PH_CEND:    return 3'd4;
         PH_TRAIL:   return 3'd5;
         PH_DONE:    return 3'd6;
         default:    return 3'd0;
      endcase
   endfunction

endpackage

### hdl/hrcd_accum.sv
// Saturating decimal/hex digit accumulator step.
module hrcd_accum import hrcd_pkg::*; #(
   parameter int W = 32
) (
   input  logic [W-1:0] acc,
   input  logic [W-1:0] max_val,
   input  logic         hex,
   input  logic [3:0]   digit,
   output logic [W-1:0] acc_out,
   output logic         ovf
);
   logic [W+4:0] prod;
   logic [W+4:0] sum;

   always_comb begin
      if (hex) begin
         prod = {1'b0, acc, 4'b0};
      end else begin
         prod = {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0};
      end
      sum = prod + {{(W+1){1'b0}}, digit};
      ovf = sum > {5'b0, max_val};
      acc_out = ovf ? max_val : sum[W-1:0];
   end
endmodule

### hdl/http_response_chunked_deframer_unit.sv
// Top level: HTTP/1.1 response deframer with chunked transfer decoding.
//  channel | ports                                   | direction
//  req     | req_valid/ready, rx_byte, new_response  | in
//  rsp     | rsp_valid/ready, body_*, phase, status..| out
// One item per cycle while results are taken; each result is registered in the cycle after acceptance.
// The output register accepts a new item whenever it is empty or being taken.
// Synchronous active-high reset clears parser state and the output valid flag.
// A stalled result holds the input back; nothing is dropped.
module http_response_chunked_deframer_unit import hrcd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_new_response,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_body_valid,
   output logic [7:0]  rsp_body_byte,
   output logic [2:0]  rsp_phase,
   output logic [9:0]  rsp_status_code,
   output logic        rsp_response_done,
   output logic [1:0]  rsp_error_code
);
   localparam int LB = LENGTH_BITS;
   localparam logic [LB-1:0] LEN_MAX = '1;

   phase_type      phase_ff, phase_in;
   logic           chunked_ff, chunked_in;
   logic [LB-1:0]  remain_ff, remain_in;
   logic           lknown_ff, lknown_in;
   logic [9:0]     status_ff, status_in;
   logic           empty_ff, empty_in;
   logic [1:0]     tok_ff, tok_in;
   logic [4:0]     npos_ff, npos_in;
   logic [1:0]     cand_ff, cand_in;
   logic           inval_ff, inval_in;
   logic [2:0]     vpos_ff, vpos_in;
   logic [LB-1:0]  acc_ff, acc_in;
   logic           stop_ff, stop_in;
   logic [1:0]     err_ff, err_in;

   logic           ov_ff;
   logic           obv_ff, obv_in;
   logic [7:0]     obb_ff, obb_in;

   logic           accept;

   // Effective state after optional new_response clear
   phase_type      p0;
   logic           ch0, lk0, em0, iv0, st0;
   logic [LB-1:0]  rm0, ac0;
   logic [9:0]     sv0;
   logic [1:0]     tk0, cd0, er0;
   logic [4:0]     np0;
   logic [2:0]     vp0;

   logic [7:0]     c, lc;
   logic           is_dig, is_hex;
   logic [3:0]     dig;
   logic [LB-1:0]  amax, acc_next;
   logic           acc_hex, ovf;
   logic [LB-1:0]  rm_dec;
   logic [1:0]     keep;
   logic [9:0]     sv_new;

   assign accept    = req_valid && req_ready;
   assign req_ready = !ov_ff || rsp_ready;

   always_comb begin
      c  = req_rx_byte;
      lc = to_lower(c);
      is_dig = c >= "0" && c <= "9";
      is_hex = is_dig || (lc >= "a" && lc <= "f");
      dig = is_dig ? c[3:0] : lc[3:0] + 4'd9;
   end

   always_comb begin
      if (req_new_response) begin
         p0 = PH_STATUS; ch0 = 1'b0; rm0 = '0; lk0 = 1'b0; sv0 = '0; er0 = ERR_NONE;
         em0 = 1'b1; tk0 = '0; np0 = '0; cd0 = 2'b11; iv0 = 1'b0; vp0 = '0;
         ac0 = '0; st0 = 1'b0;
      end else begin
         p0 = phase_ff; ch0 = chunked_ff; rm0 = remain_ff; lk0 = lknown_ff;
         sv0 = status_ff; er0 = err_ff; em0 = empty_ff; tk0 = tok_ff; np0 = npos_ff;
         cd0 = cand_ff; iv0 = inval_ff; vp0 = vpos_ff; ac0 = acc_ff; st0 = stop_ff;
      end
   end

   assign acc_hex = (p0 == PH_CLEN);
   assign amax    = (p0 == PH_STATUS) ? LB'(STATUS_MAX) : LEN_MAX;

   hrcd_accum #(.W(LB)) u_accum (
      .acc     (ac0),
      .max_val (amax),
      .hex     (acc_hex),
      .digit   (dig),
      .acc_out (acc_next),
      .ovf     (ovf)
   );

   assign rm_dec = (rm0 != '0) ? rm0 - LB'(1) : rm0;
   assign keep   = {npos_ff == 5'(TE_LEN) && !req_new_response,
                    npos_ff == 5'(CL_LEN) && !req_new_response};
   assign sv_new = ac0[9:0];

   always_comb begin
      phase_in = p0; chunked_in = ch0; remain_in = rm0; lknown_in = lk0;
      status_in = sv0; err_in = er0; empty_in = em0; tok_in = tk0; npos_in = np0;
      cand_in = cd0; inval_in = iv0; vpos_in = vp0; acc_in = ac0; stop_in = st0;
      obv_in = 1'b0; obb_in = 8'h00;

      if (p0 == PH_BODY) begin
         obv_in = 1'b1; obb_in = c;
         if (ch0 || lk0) begin
            remain_in = rm_dec;
            if (rm_dec == '0) phase_in = ch0 ? PH_CEND : PH_DONE;
         end
      end else if (p0 != PH_DONE) begin
         if (c == CH_LF) begin
            case (p0)
               PH_STATUS: begin
                  status_in = sv_new;
                  if ((sv_new < 10'd100 || sv_new > 10'd599) && er0 == ERR_NONE)
                     err_in = ERR_STATUS;
                  phase_in = PH_HEADERS;
               end
               PH_HEADERS: begin
                  if (em0) begin
                     if (sv0 == 10'd100) phase_in = PH_STATUS;
                     else if (sv0 == 10'd204 || sv0 == 10'd304 ||
                              (sv0 >= 10'd100 && sv0 <= 10'd199)) phase_in = PH_DONE;
                     else if (ch0) phase_in = PH_CLEN;
                     else if (lk0 && rm0 == '0) phase_in = PH_DONE;
                     else phase_in = PH_BODY;
                  end else if (!iv0) begin
                     if (er0 == ERR_NONE) err_in = ERR_NO_COLON;
                  end else if (cd0[0]) begin
                     remain_in = ac0; lknown_in = 1'b1;
                  end else if (cd0[1]) begin
                     chunked_in = (vp0 == 3'(CHUNKED_LEN)) && !st0;
                  end
               end
               PH_CLEN: begin
                  if (ac0 != '0) begin
                     remain_in = ac0; phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_TRAIL;
                  end
               end
               PH_CEND: phase_in = PH_CLEN;
               PH_TRAIL: if (em0) phase_in = PH_DONE;
               default: ;
            endcase
            empty_in = 1'b1; tok_in = '0; npos_in = '0; cand_in = 2'b11;
            inval_in = 1'b0; vpos_in = '0; acc_in = '0; stop_in = 1'b0;
         end else if (c != CH_CR) begin
            empty_in = 1'b0;
            case (p0)
               PH_STATUS: begin
                  case (tk0)
                     2'd0: if (c != CH_SP) tok_in = 2'd1;
                     2'd1: if (c == CH_SP) tok_in = 2'd2;
                     2'd2: begin
                        if (c == CH_SP) begin
                           if (iv0) tok_in = 2'd3;
                        end else begin
                           inval_in = 1'b1;
                           if (!st0) begin
                              if (is_dig) begin
                                 acc_in = acc_next;
                                 if (ovf && er0 == ERR_NONE) err_in = ERR_OVERFLOW;
                              end else stop_in = 1'b1;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
               PH_HEADERS: begin
                  if (!iv0) begin
                     if (c == CH_COLON) begin
                        cand_in = cd0 & keep;
                        inval_in = 1'b1;
                     end else begin
                        cand_in = cd0 & {np0 < 5'(TE_LEN) && lc == te_char(np0),
                                         np0 < 5'(CL_LEN) && lc == cl_char(np0)};
                        if (np0 < 5'd31) npos_in = np0 + 5'd1;
                     end
                  end else if (cd0[0]) begin
                     if (!(c == CH_SP && vp0 == '0)) begin
                        vpos_in = 3'd1;
                        if (!st0) begin
                           if (is_dig) begin
                              acc_in = acc_next;
                              if (ovf && er0 == ERR_NONE) err_in = ERR_OVERFLOW;
                           end else stop_in = 1'b1;
                        end
                     end
                  end else if (cd0[1]) begin
                     if (!(st0 || vp0 >= 3'(CHUNKED_LEN)) && !(c == CH_SP && vp0 == '0)) begin
                        if (lc == chunked_char(vp0)) vpos_in = vp0 + 3'd1;
                        else stop_in = 1'b1;
                     end
                  end
               end
               PH_CLEN: begin
                  if (iv0 || !(c == CH_SP || c == CH_TAB)) begin
                     inval_in = 1'b1;
                     if (!st0) begin
                        if (is_hex) begin
                           acc_in = acc_next;
                           if (ovf && er0 == ERR_NONE) err_in = ERR_OVERFLOW;
                        end else stop_in = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STATUS; chunked_ff <= 1'b0; remain_ff <= '0; lknown_ff <= 1'b0;
         status_ff <= '0; err_ff <= ERR_NONE; empty_ff <= 1'b1; tok_ff <= '0;
         npos_ff <= '0; cand_ff <= 2'b11; inval_ff <= 1'b0; vpos_ff <= '0;
         acc_ff <= '0; stop_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in; chunked_ff <= chunked_in; remain_ff <= remain_in;
            lknown_ff <= lknown_in; status_ff <= status_in; err_ff <= err_in;
            empty_ff <= empty_in; tok_ff <= tok_in; npos_ff <= npos_in;
            cand_ff <= cand_in; inval_ff <= inval_in; vpos_ff <= vpos_in;
            acc_ff <= acc_in; stop_ff <= stop_in;
            ov_ff <= 1'b1;
         end else if (rsp_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         obv_ff <= obv_in;
         obb_ff <= obb_in;
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_body_valid    = obv_ff;
   assign rsp_body_byte     = obb_ff;
   assign rsp_phase         = phase_code(phase_ff);
   assign rsp_status_code   = status_ff;
   assign rsp_response_done = phase_ff == PH_DONE;
   assign rsp_error_code    = err_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase))
      else $error("result changed while stalled");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      accept && !req_new_response && err_ff != ERR_NONE |=> $stable(err_ff))
      else $error("error code not sticky");
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && !req_new_response && phase_ff == PH_DONE |=> !obv_ff && phase_ff == PH_DONE)
      else $error("activity after completion");
   a_status_rng: assert property (@(posedge clock) disable iff (reset)
      status_ff <= STATUS_MAX)
      else $error("status out of range");
endmodule
